FILE: src/aept_pkg.sv
// ============================================================================
// Audio edge partition tracker - shared definitions
// Widths, register indexes, reset values and word layouts for the tracker.
// ============================================================================
package aept_pkg;

    // Sample and configuration widths
    localparam int SAMPLE_BITS = 16;
    localparam int THR_BITS    = 16;

    // Saturating run counters and wrapping message counter
    localparam int RUN_BITS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int PIDX_BITS  = 16;

    // Common width for run vs threshold compares
    localparam int CMP_BITS  = (RUN_BITS > THR_BITS) ? RUN_BITS : THR_BITS;
    // Message counter widened so the partition index can always be selected
    localparam int CNTX_BITS = (COUNT_BITS > PIDX_BITS) ? COUNT_BITS : PIDX_BITS;

    // Run length at or below which the handshake phase ends
    localparam logic [RUN_BITS-1:0] SHORT_RUN = RUN_BITS'(3);

    // Configuration port
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_THR = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_RUN = CFG_IDX_BITS'(1);

    localparam logic [THR_BITS-1:0] EDGE_THR_RESET = THR_BITS'(1000);
    localparam logic [THR_BITS-1:0] LONG_RUN_RESET = THR_BITS'(64);

    // Stream word widths (output padded to whole bytes)
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_USED_BITS = 1 + 1 + 2 + PIDX_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

endpackage

FILE: src/audio_edge_partition_tracker_top.sv
// ============================================================================
// Audio edge partition tracker - top level
// Recovers a digital level from audio sample differences and tracks a
// three-phase idle / handshake / message machine with a message counter.
// ============================================================================
// Usage:
//   Input stream (i_s_axis_*): one signed 16-bit sample per word.
//   Output stream (o_m_axis_*): one result word per accepted sample, in order.
//   Config channel (i_cfg_*): index 0 writes the edge threshold, index 1 the
//   long run threshold; o_cfg_ready is always high. Write only while idle.
// Timing:
//   A sample taken at one edge lands in the input register, is evaluated by
//   one shallow level of compare / count logic, and is loaded into the result
//   register once that register is free: throughput 1 word per cycle while
//   i_m_axis_tready stays high, set by the state update loop.
// Reset:
//   Thresholds return to 1000 and 64, runs, phase and message count clear;
//   the first sample afterwards only primes the previous sample and level.
// Backpressure:
//   When the receiver holds i_m_axis_tready low, the result register and the
//   input register each hold one word; o_s_axis_tready drops once both fill.
// ============================================================================
module audio_edge_partition_tracker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] sample (signed)
    input  logic [aept_pkg::IN_DATA_BITS-1:0] i_s_axis_tdata,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] phase_changed, [1] level, [3:2] phase, [19:4] partition_index,
    // upper bits zero
    output logic [aept_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aept_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [aept_pkg::THR_BITS-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_HANDSHAKE = 2'd1,
        PH_MESSAGE   = 2'd2
    } t_phase;

    localparam logic [aept_pkg::RUN_BITS-1:0] RUN_MAX = '1;

    // Configuration registers
    logic [aept_pkg::THR_BITS-1:0]    r_edge_thr;
    logic [aept_pkg::THR_BITS-1:0]    r_long_thr;

    // Input stage
    logic                             r_in_valid;
    logic signed [aept_pkg::SAMPLE_BITS-1:0] r_in_sample;

    // Tracker state
    logic                             r_primed;
    logic [aept_pkg::SAMPLE_BITS-1:0] r_last_sample;
    logic                             r_last_level;
    logic [aept_pkg::RUN_BITS-1:0]    r_high_run;
    logic [aept_pkg::RUN_BITS-1:0]    r_low_run;
    t_phase                           r_phase;
    logic [aept_pkg::COUNT_BITS-1:0]  r_msg;

    // Result register
    logic                             r_out_valid;
    logic                             r_out_changed;
    logic                             r_out_level;
    t_phase                           r_out_phase;
    logic [aept_pkg::PIDX_BITS-1:0]   r_out_pidx;

    // Next values
    logic                             n_level;
    logic [aept_pkg::RUN_BITS-1:0]    n_high_run;
    logic [aept_pkg::RUN_BITS-1:0]    n_low_run;
    t_phase                           n_phase;
    logic                             n_changed;
    logic [aept_pkg::COUNT_BITS-1:0]  n_msg;
    logic [aept_pkg::PIDX_BITS-1:0]   n_pidx;

    logic                             out_free;
    logic                             advance;

    logic signed [aept_pkg::SAMPLE_BITS+1:0] diff;
    logic signed [aept_pkg::SAMPLE_BITS+1:0] thr_pos;
    logic signed [aept_pkg::SAMPLE_BITS+1:0] thr_neg;
    logic [aept_pkg::CMP_BITS-1:0]    high_cmp;
    logic [aept_pkg::CMP_BITS-1:0]    low_cmp;
    logic [aept_pkg::CMP_BITS-1:0]    long_cmp;
    logic [aept_pkg::CNTX_BITS-1:0]   msg_wide;

    // Handshake: result register frees when empty or taken
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready     = 1'b1;

    // Level recovery from the sample difference
    always_comb begin
        diff    = (aept_pkg::SAMPLE_BITS+2)'(r_in_sample)
                - (aept_pkg::SAMPLE_BITS+2)'($signed(r_last_sample));
        thr_pos = $signed({2'b00, r_edge_thr});
        thr_neg = -thr_pos;
        if (diff >= thr_pos) begin
            n_level = 1'b1;
        end else if (diff <= thr_neg) begin
            n_level = 1'b0;
        end else begin
            n_level = r_last_level;
        end
    end

    // Saturating run counters
    always_comb begin
        if (n_level) begin
            n_high_run = (r_high_run == RUN_MAX) ? RUN_MAX : r_high_run + 1'b1;
            n_low_run  = '0;
        end else begin
            n_high_run = '0;
            n_low_run  = (r_low_run == RUN_MAX) ? RUN_MAX : r_low_run + 1'b1;
        end
        high_cmp = aept_pkg::CMP_BITS'(n_high_run);
        low_cmp  = aept_pkg::CMP_BITS'(n_low_run);
        long_cmp = aept_pkg::CMP_BITS'(r_long_thr);
    end

    // Phase machine and message counter
    always_comb begin
        n_phase   = r_phase;
        n_changed = 1'b0;
        n_msg     = r_msg;
        unique case (r_phase)
            PH_IDLE: begin
                if (low_cmp >= long_cmp) begin
                    n_phase   = PH_HANDSHAKE;
                    n_changed = 1'b1;
                end
            end
            PH_HANDSHAKE: begin
                if (n_low_run <= aept_pkg::SHORT_RUN &&
                    n_high_run <= aept_pkg::SHORT_RUN) begin
                    n_phase   = PH_MESSAGE;
                    n_changed = 1'b1;
                end
            end
            PH_MESSAGE: begin
                if (low_cmp >= long_cmp || high_cmp >= long_cmp) begin
                    n_phase   = PH_IDLE;
                    n_changed = 1'b1;
                    n_msg     = r_msg + 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Partition index: low bits of the message counter
    always_comb begin
        if (r_primed) begin
            msg_wide = aept_pkg::CNTX_BITS'(n_msg);
        end else begin
            msg_wide = aept_pkg::CNTX_BITS'(r_msg);
        end
        n_pidx = msg_wide[aept_pkg::PIDX_BITS-1:0];
    end

    // Registers: config, input stage, tracker state, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_thr    <= aept_pkg::EDGE_THR_RESET;
            r_long_thr    <= aept_pkg::LONG_RUN_RESET;
            r_in_valid    <= 1'b0;
            r_primed      <= 1'b0;
            r_last_sample <= '0;
            r_last_level  <= 1'b0;
            r_high_run    <= '0;
            r_low_run     <= '0;
            r_phase       <= PH_IDLE;
            r_msg         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // Take configuration words
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    aept_pkg::REG_EDGE_THR: r_edge_thr <= i_cfg_data;
                    aept_pkg::REG_LONG_RUN: r_long_thr <= i_cfg_data;
                    default:                r_edge_thr <= r_edge_thr;
                endcase
            end

            // Hold or refill the input stage
            if (o_s_axis_tready) begin
                r_in_valid  <= i_s_axis_tvalid;
                r_in_sample <= i_s_axis_tdata;
            end

            // Advance tracker state and load the result
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_primed      <= 1'b1;
                r_last_sample <= r_in_sample;
                r_out_pidx    <= n_pidx;
                if (!r_primed) begin
                    r_last_level  <= 1'b1;
                    r_out_changed <= 1'b0;
                    r_out_level   <= 1'b1;
                    r_out_phase   <= r_phase;
                end else begin
                    r_last_level  <= n_level;
                    r_high_run    <= n_high_run;
                    r_low_run     <= n_low_run;
                    r_phase       <= n_phase;
                    r_msg         <= n_msg;
                    r_out_changed <= n_changed;
                    r_out_level   <= n_level;
                    r_out_phase   <= n_phase;
                end
            end
        end
    end

    // Drive the result word
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = aept_pkg::OUT_DATA_BITS'(
        {r_out_pidx, r_out_phase, r_out_level, r_out_changed});

`ifndef NO_ASSERTIONS
    // At most one run counter is nonzero
    a_one_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high_run == '0) || (r_low_run == '0))
        else $error("both run counters nonzero");

    // Before priming, the tracker state stays at its reset values
    a_unprimed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (r_phase == PH_IDLE && r_msg == '0 &&
                       r_high_run == '0 && r_low_run == '0))
        else $error("state moved before first sample");

    // The message counter only steps when a message ends
    a_msg_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_msg != $past(r_msg)) |->
            ($past(r_phase) == PH_MESSAGE && r_phase == PH_IDLE))
        else $error("message count changed outside message end");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Audio edge partition tracker - testbench
// Streams signed samples through the tracker while the source idles and the
// sink stalls at random. An in-bench model of the edge detector, the run
// counters and the idle / handshake / message machine predicts every result
// word, and each word is checked field by field in arrival order. Closing
// sections run a burst of short messages and a long high run inside a message.
// ============================================================================
module testbench;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_HANDSHAKE = 2'd1,
        PH_MESSAGE   = 2'd2
    } t_phase;

    typedef struct {
        logic        changed;
        logic        level;
        t_phase      phase;
        logic [15:0] pidx;
    } t_tracker_word;

    localparam int SHORT_RUN_MAX     = 3;
    localparam int SETTLE_CYCLES     = 4;
    localparam int HOLD_CYCLES       = 300;
    localparam int MSG_TRIPLES       = 30;
    localparam int HIGH_HOLD_SAMPLES = 40;

    // ------------------------------------------------------------------------
    // Tracker model and queue of expected result words
    // ------------------------------------------------------------------------
    class tracker_scoreboard;
        logic [15:0]   edge_thr;
        logic [15:0]   long_thr;
        bit            primed;
        logic [15:0]   prev_sample;
        bit            level;
        logic [15:0]   high_run;
        logic [15:0]   low_run;
        t_phase        phase;
        logic [15:0]   msg_count;
        t_tracker_word expected_q[$];
        int unsigned   errors;
        int unsigned   samples;
        int unsigned   words;
        int unsigned   changes;
        int unsigned   wraps;
        bit            saturated;

        function new();
            edge_thr    = aept_pkg::EDGE_THR_RESET;
            long_thr    = aept_pkg::LONG_RUN_RESET;
            primed      = 1'b0;
            prev_sample = '0;
            level       = 1'b0;
            high_run    = '0;
            low_run     = '0;
            phase       = PH_IDLE;
            msg_count   = '0;
            errors      = 0;
            samples     = 0;
            words       = 0;
            changes     = 0;
            wraps       = 0;
            saturated   = 1'b0;
        endfunction

        function void load_register(logic [aept_pkg::CFG_IDX_BITS-1:0] idx,
                                    logic [15:0] val);
            case (idx)
                aept_pkg::REG_EDGE_THR: edge_thr = val;
                aept_pkg::REG_LONG_RUN: long_thr = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the model by one accepted sample and queue its result word
        function void note_sample(logic [15:0] raw);
            int            diff;
            bit            lvl;
            t_tracker_word w;
            w.changed = 1'b0;
            samples++;
            if (!primed) begin
                // first sample after reset only primes the previous sample and level
                primed      = 1'b1;
                prev_sample = raw;
                level       = 1'b1;
            end else begin
                diff = int'($signed(raw)) - int'($signed(prev_sample));
                lvl  = level;
                if (diff >= int'(edge_thr))
                    lvl = 1'b1;
                else if (diff <= -int'(edge_thr))
                    lvl = 1'b0;

                // saturating run counters, the other run clears
                if (lvl) begin
                    if (high_run != 16'hFFFF)
                        high_run++;
                    else
                        saturated = 1'b1;
                    low_run = '0;
                end else begin
                    if (low_run != 16'hFFFF)
                        low_run++;
                    else
                        saturated = 1'b1;
                    high_run = '0;
                end

                case (phase)
                    PH_IDLE: begin
                        if (low_run >= long_thr) begin
                            phase     = PH_HANDSHAKE;
                            w.changed = 1'b1;
                        end
                    end
                    PH_HANDSHAKE: begin
                        if (low_run <= SHORT_RUN_MAX && high_run <= SHORT_RUN_MAX) begin
                            phase     = PH_MESSAGE;
                            w.changed = 1'b1;
                        end
                    end
                    PH_MESSAGE: begin
                        if (low_run >= long_thr || high_run >= long_thr) begin
                            phase     = PH_IDLE;
                            w.changed = 1'b1;
                            msg_count++;
                            if (msg_count == 0)
                                wraps++;
                        end
                    end
                    default: ;
                endcase

                prev_sample = raw;
                level       = lvl;
            end
            if (w.changed)
                changes++;
            w.level = level;
            w.phase = phase;
            w.pidx  = msg_count;
            expected_q.push_back(w);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
            errors++;
        endtask

        // Compare one accepted result word against the oldest expectation
        task check_word(logic [aept_pkg::OUT_DATA_BITS-1:0] word);
            t_tracker_word w;
            words++;
            if (expected_q.size() == 0) begin
                report_mismatch("result word with nothing expected", 32'(word), 32'(0));
                return;
            end
            w = expected_q.pop_front();
            if (word[0] !== w.changed)
                report_mismatch("phase_changed", 32'(word[0]), 32'(w.changed));
            if (word[1] !== w.level)
                report_mismatch("level", 32'(word[1]), 32'(w.level));
            if (word[3:2] !== w.phase)
                report_mismatch("phase", 32'(word[3:2]), 32'(w.phase));
            if (word[19:4] !== w.pidx)
                report_mismatch("partition_index", 32'(word[19:4]), 32'(w.pidx));
            if (word[aept_pkg::OUT_DATA_BITS-1:20] !== '0)
                report_mismatch("padding bits",
                                32'(word[aept_pkg::OUT_DATA_BITS-1:20]), 32'(0));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_valid   = 1'b0;
    logic [aept_pkg::IN_DATA_BITS-1:0] s_data    = '0;
    logic                              m_ready   = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic [aept_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [aept_pkg::THR_BITS-1:0]     cfg_data  = '0;

    wire                               s_ready;
    wire                               m_valid;
    wire [aept_pkg::OUT_DATA_BITS-1:0] m_data;
    wire                               cfg_ready;

    bit idling   = 1'b1;
    bit hold_req = 1'b0;
    int last_sent = 0;

    tracker_scoreboard sb;

    always #2 clk = ~clk;

    audio_edge_partition_tracker_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Sample both handshakes mid-cycle, where every signal is settled
    always @(negedge clk) begin
        if (rst_n) begin
            if (s_valid && s_ready)
                sb.note_sample(s_data);
            if (m_valid && m_ready)
                sb.check_word(m_data);
        end
    end

    // Sink: random stalls, plus one long hold-off on request
    initial begin : sink
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_ready <= !idling || ($urandom_range(0, 99) >= 20);
        end
    end

    initial begin : watchdog
        #20ms;
        $display("Timeout with %0d result words still expected", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    function automatic int clamp16(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    // Offer one sample word, with an occasional gap, and hold until taken
    task automatic send_sample(input int v);
        if (idling && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= 16'(v);
        @(negedge clk);
        while (!s_ready)
            @(negedge clk);
        @(posedge clk);
        last_sent = v;
    endtask

    // Park the source and wait until every expected word has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic wait_cfg();
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Write both thresholds while the tracker is quiet
    task automatic configure(input logic [15:0] edge_v, input logic [15:0] long_v);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= aept_pkg::REG_EDGE_THR;
        cfg_data  <= edge_v;
        wait_cfg();
        sb.load_register(aept_pkg::REG_EDGE_THR, edge_v);
        cfg_index <= aept_pkg::REG_LONG_RUN;
        cfg_data  <= long_v;
        wait_cfg();
        sb.load_register(aept_pkg::REG_LONG_RUN, long_v);
        cfg_valid <= 1'b0;
    endtask

    // One run of a level: an edge past the threshold, then sub-threshold drift
    task automatic send_run(input bit go_high, input int len);
        int thr;
        int spread;
        int v;
        int k;
        thr    = int'(sb.edge_thr);
        spread = (thr > 1) ? ((thr - 1 < 256) ? thr - 1 : 256) : 0;
        v = last_sent + (go_high ? 1 : -1) * (thr + int'($urandom_range(0, 64)));
        send_sample(clamp16(v));
        for (k = 1; k < len; k++) begin
            v = last_sent + int'($urandom_range(0, 2 * spread)) - spread;
            send_sample(clamp16(v));
        end
    endtask

    // Mostly alternating runs of short and long length, some raw noise
    task automatic random_phase(input int n);
        int start;
        int pick;
        int len;
        start = sb.samples;
        while (sb.samples - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_sample(int'($urandom_range(0, 65535)) - 32768);
            end else begin
                if (pick < 50)
                    len = $urandom_range(1, 3);
                else if (pick < 85)
                    len = int'(sb.long_thr) + int'($urandom_range(0, 3)) - 1;
                else
                    len = $urandom_range(1, 24);
                if (len < 1)
                    len = 1;
                send_run(!sb.level, len);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int opening [10] = '{-32768, 32767, -32768, 0, 1000, 1, -999, -1, 21845, -21846};
        int k;
        int lo;
        int hi;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Priming sample, rail-to-rail swings, differences right at the threshold
        for (k = 0; k < 10; k++)
            send_sample(opening[k]);

        // Shortest message: every phase change within a few samples
        configure(16'd1, 16'd1);
        send_sample(100);
        send_sample(0);
        send_sample(0);
        send_sample(100);

        // Zero edge threshold: rises and flat steps go high, falls go low
        configure(16'd0, 16'd64);
        send_sample(10);
        send_sample(5);
        send_sample(-5);
        send_sample(-5);

        // Largest edge threshold: only a full-scale step is an edge
        configure(16'hFFFF, 16'd3);
        send_sample(-32768);
        send_sample(32767);
        send_sample(-32768);
        send_sample(0);

        // Random runs under several threshold settings
        configure(aept_pkg::EDGE_THR_RESET, aept_pkg::LONG_RUN_RESET);
        random_phase(150);

        idling = 1'b0;
        configure(16'd300, 16'd4);
        random_phase(150);
        idling = 1'b1;

        configure(16'd1, 16'd1);
        random_phase(100);

        configure(16'hFFFF, 16'd2);
        random_phase(100);

        // Long sink hold-off while the source keeps offering words
        configure(16'($urandom_range(1, 5000)), 16'($urandom_range(1, 10)));
        hold_req = 1'b1;
        random_phase(100);
        drain();
        random_phase(100);

        configure(16'd50, 16'd16);
        random_phase(100);

        configure(16'd2000, 16'd8);
        random_phase(100);

        // Low, low, high triples: one short message each
        configure(16'd1, 16'd1);
        for (k = 0; k < MSG_TRIPLES; k++) begin
            lo = int'($urandom_range(0, 32767)) - 32768;
            hi = int'($urandom_range(0, 32767));
            send_sample(lo);
            send_sample(lo);
            send_sample(hi);
        end

        // Enter a message, then hold high for a long run without ending it
        configure(16'd1, 16'd4);
        for (k = 0; k < 12; k++)
            send_sample(-32768);
        send_sample(32767);
        configure(16'd1, 16'hFFFF);
        for (k = 0; k < HIGH_HOLD_SAMPLES; k++)
            send_sample(32767);

        drain();
        $display("Covered %0d samples and %0d result words, %0d phase changes, %0d counter wraps",
                 sb.samples, sb.words, sb.changes, sb.wraps);
        $display("Run counter saturation %0s; edge threshold 0 to 65535, long run 1 to 65535",
                 sb.saturated ? "reached" : "not reached");
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
src/aept_pkg.sv
src/audio_edge_partition_tracker_top.sv
bench/testbench.sv
